[design/fcg_pkg.sv]
package fcg_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int FRACTION_BITS = 16;

  localparam int CFG_SIZE_W = 11;
  localparam int RGB_W      = 24;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 10;
  localparam int ARGB_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RGB_W;

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int CMP_W   = (DIM_W > CFG_SIZE_W) ? DIM_W : CFG_SIZE_W;

  localparam int VAL_W = CHAN_W + FRACTION_BITS + 1;
  localparam int MAG_W = CHAN_W + FRACTION_BITS;

  localparam logic [DIM_W-1:0] MAX_WIDTH_DIM  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_HEIGHT_DIM = DIM_W'(MAX_HEIGHT);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT_RGB     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_RIGHT_RGB    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_RIGHT_RGB = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LEFT_RGB  = 3'd5;

  localparam logic [CFG_SIZE_W-1:0] RST_FRAME_WIDTH      = 11'd800;
  localparam logic [CFG_SIZE_W-1:0] RST_FRAME_HEIGHT     = 11'd600;
  localparam logic [RGB_W-1:0]      RST_TOP_LEFT_RGB     = 24'hFF0000;
  localparam logic [RGB_W-1:0]      RST_TOP_RIGHT_RGB    = 24'h0000FF;
  localparam logic [RGB_W-1:0]      RST_BOTTOM_RIGHT_RGB = 24'h00FF00;
  localparam logic [RGB_W-1:0]      RST_BOTTOM_LEFT_RGB  = 24'hFFFF00;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  localparam int JOB_W = 4;
  localparam logic [JOB_W-1:0] JOB_LEFT_FIRST  = 4'd0;
  localparam logic [JOB_W-1:0] JOB_RIGHT_FIRST = 4'd3;
  localparam logic [JOB_W-1:0] JOB_EDGE_LAST   = 4'd5;
  localparam logic [JOB_W-1:0] JOB_ROW_FIRST   = 4'd6;
  localparam logic [JOB_W-1:0] JOB_ROW_LAST    = 4'd8;

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_ROW,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } fcg_state_t;

  typedef struct packed {
    logic             frame_load;
    logic             row_load;
    logic             div_start;
    logic             div_write;
    logic             emit;
    logic [JOB_W-1:0] job;
  } fcg_cmd_t;

  typedef struct packed {
    logic start_pending;
    logic row_pending;
    logic div_done;
    logic out_free;
  } fcg_stat_t;

  function automatic logic [DIM_W-1:0] clamp_size(input logic [CFG_SIZE_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
    logic [CMP_W-1:0] ve;
    logic [CMP_W-1:0] me;
    ve = CMP_W'(v);
    me = CMP_W'(maxv);
    if (ve == '0) begin
      return DIM_W'(1);
    end else if (ve > me) begin
      return maxv;
    end else begin
      return DIM_W'(v);
    end
  endfunction

  function automatic logic [CHAN_W-1:0] chan_byte(input logic [RGB_W-1:0] rgb,
                                                  input logic [1:0] chan);
    logic [CHAN_W-1:0] b;
    unique case (chan)
      CHAN_RED:   b = rgb[23:16];
      CHAN_GREEN: b = rgb[15:8];
      CHAN_BLUE:  b = rgb[7:0];
      default:    b = '0;
    endcase
    return b;
  endfunction

  function automatic val_t fix_of(input logic [CHAN_W-1:0] b);
    return $signed({1'b0, b, {FRACTION_BITS{1'b0}}});
  endfunction

  function automatic logic [CHAN_W-1:0] chan_out(input val_t v);
    if (v[VAL_W-1]) begin
      return '0;
    end else begin
      return v[VAL_W-2:FRACTION_BITS];
    end
  endfunction

endpackage

[design/fcg_div.sv]
module fcg_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [fcg_pkg::MAG_W-1:0]         dividend,
  input  logic [fcg_pkg::DIM_W-1:0]         divisor,
  output logic                              done,
  output logic [fcg_pkg::MAG_W-1:0]         quotient
);

  localparam int CNT_W = $clog2(fcg_pkg::MAG_W + 1);

  logic [fcg_pkg::DIM_W:0]   rem_r, rem_nxt;
  logic [fcg_pkg::MAG_W-1:0] quo_r, quo_nxt;
  logic [fcg_pkg::DIM_W-1:0] dsr_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [fcg_pkg::DIM_W:0]   rem_sh;
  logic [fcg_pkg::DIM_W:0]   trial;

  always_comb begin
    rem_sh = {rem_r[fcg_pkg::DIM_W-1:0], quo_r[fcg_pkg::MAG_W-1]};
    trial  = rem_sh - {1'b0, dsr_r};
    if (!trial[fcg_pkg::DIM_W]) begin
      rem_nxt = trial;
      quo_nxt = {quo_r[fcg_pkg::MAG_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh;
      quo_nxt = {quo_r[fcg_pkg::MAG_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(fcg_pkg::MAG_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[design/fcg_ctrl.sv]
module fcg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_restart_frame,
  output logic                in_stall,
  input  fcg_pkg::fcg_stat_t  stat,
  output fcg_pkg::fcg_cmd_t   cmd
);

  fcg_pkg::fcg_state_t            state_r, state_nxt;
  logic [fcg_pkg::JOB_W-1:0]      job_r, job_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcg_pkg::ST_IDLE;
      job_r   <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    unique case (state_r)
      fcg_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_restart_frame || stat.start_pending) begin
            state_nxt = fcg_pkg::ST_FRAME;
          end else if (stat.row_pending) begin
            state_nxt = fcg_pkg::ST_ROW;
          end else begin
            state_nxt = fcg_pkg::ST_EMIT;
          end
        end
      end
      fcg_pkg::ST_FRAME: begin
        job_nxt   = fcg_pkg::JOB_LEFT_FIRST;
        state_nxt = fcg_pkg::ST_DIV_GO;
      end
      fcg_pkg::ST_ROW: begin
        job_nxt   = fcg_pkg::JOB_ROW_FIRST;
        state_nxt = fcg_pkg::ST_DIV_GO;
      end
      fcg_pkg::ST_DIV_GO: begin
        state_nxt = fcg_pkg::ST_DIV_WAIT;
      end
      fcg_pkg::ST_DIV_WAIT: begin
        if (stat.div_done) begin
          if (job_r == fcg_pkg::JOB_EDGE_LAST) begin
            state_nxt = fcg_pkg::ST_ROW;
          end else if (job_r == fcg_pkg::JOB_ROW_LAST) begin
            state_nxt = fcg_pkg::ST_EMIT;
          end else begin
            job_nxt   = job_r + 1'b1;
            state_nxt = fcg_pkg::ST_DIV_GO;
          end
        end
      end
      fcg_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          state_nxt = fcg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fcg_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.job  = job_r;
    in_stall = (state_r != fcg_pkg::ST_IDLE);
    unique case (state_r)
      fcg_pkg::ST_IDLE:     ;
      fcg_pkg::ST_FRAME:    cmd.frame_load = 1'b1;
      fcg_pkg::ST_ROW:      cmd.row_load   = 1'b1;
      fcg_pkg::ST_DIV_GO:   cmd.div_start  = 1'b1;
      fcg_pkg::ST_DIV_WAIT: cmd.div_write  = stat.div_done;
      fcg_pkg::ST_EMIT:     cmd.emit       = stat.out_free;
      default:              ;
    endcase
  end

endmodule

[design/fcg_datapath.sv]
module fcg_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [fcg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fcg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  fcg_pkg::fcg_cmd_t                 cmd,
  output fcg_pkg::fcg_stat_t                stat,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fcg_pkg::PIX_W-1:0]         out_pixel_x,
  output logic [fcg_pkg::PIX_W-1:0]         out_pixel_y,
  output logic [fcg_pkg::ARGB_W-1:0]        out_argb_colour,
  output logic                              out_frame_end
);

  logic [fcg_pkg::CFG_SIZE_W-1:0] width_cfg_r, height_cfg_r;
  logic [fcg_pkg::RGB_W-1:0]      tl_rgb_r, tr_rgb_r, br_rgb_r, bl_rgb_r;

  logic [fcg_pkg::DIM_W-1:0] live_w_r, live_h_r;
  logic [fcg_pkg::POS_W-1:0] col_r, row_r;
  logic                      start_pending_r;
  logic                      row_pending_r;

  fcg_pkg::val_t left_edge_r  [0:2];
  fcg_pkg::val_t right_edge_r [0:2];
  fcg_pkg::val_t left_step_r  [0:2];
  fcg_pkg::val_t right_step_r [0:2];
  fcg_pkg::val_t row_val_r    [0:2];
  fcg_pkg::val_t row_step_r   [0:2];

  logic div_neg_r, div_zero_r;

  logic                      out_valid_r;
  logic [fcg_pkg::PIX_W-1:0] pix_x_r, pix_y_r;
  logic [fcg_pkg::ARGB_W-1:0] argb_r;
  logic                      frame_end_r;

  logic                        job_left, job_right, job_row;
  logic [1:0]                  chan;
  fcg_pkg::val_t               diff;
  logic                        diff_neg;
  fcg_pkg::val_t               diff_abs;
  logic [fcg_pkg::DIM_W-1:0]   divisor;
  logic                        div_done;
  logic [fcg_pkg::MAG_W-1:0]   quotient;
  fcg_pkg::val_t               q_ext;
  fcg_pkg::val_t               step_val;
  logic                        last_col, last_row;
  logic                        out_free;

  always_comb begin
    job_left  = (cmd.job < fcg_pkg::JOB_RIGHT_FIRST);
    job_right = !job_left && (cmd.job < fcg_pkg::JOB_ROW_FIRST);
    job_row   = !job_left && !job_right;
    if (job_left) begin
      chan = cmd.job[1:0];
    end else if (job_right) begin
      chan = 2'(cmd.job - fcg_pkg::JOB_RIGHT_FIRST);
    end else begin
      chan = 2'(cmd.job - fcg_pkg::JOB_ROW_FIRST);
    end

    if (job_left) begin
      diff = fcg_pkg::fix_of(fcg_pkg::chan_byte(bl_rgb_r, chan))
           - fcg_pkg::fix_of(fcg_pkg::chan_byte(tl_rgb_r, chan));
    end else if (job_right) begin
      diff = fcg_pkg::fix_of(fcg_pkg::chan_byte(br_rgb_r, chan))
           - fcg_pkg::fix_of(fcg_pkg::chan_byte(tr_rgb_r, chan));
    end else begin
      diff = right_edge_r[chan] - left_edge_r[chan];
    end
    diff_neg = diff[fcg_pkg::VAL_W-1];
    diff_abs = diff_neg ? -diff : diff;
    divisor  = job_row ? fcg_pkg::DIM_W'(live_w_r - 1'b1)
                       : fcg_pkg::DIM_W'(live_h_r - 1'b1);

    q_ext = $signed({1'b0, quotient});
    if (div_zero_r) begin
      step_val = '0;
    end else if (div_neg_r) begin
      step_val = -q_ext;
    end else begin
      step_val = q_ext;
    end

    last_col = ({1'b0, fcg_pkg::DIM_W'(col_r)} + 1'b1) >= {1'b0, live_w_r};
    last_row = ({1'b0, fcg_pkg::DIM_W'(row_r)} + 1'b1) >= {1'b0, live_h_r};
    out_free = !out_valid_r || !out_stall;
  end

  fcg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (diff_abs[fcg_pkg::MAG_W-1:0]),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= fcg_pkg::RST_FRAME_WIDTH;
      height_cfg_r <= fcg_pkg::RST_FRAME_HEIGHT;
      tl_rgb_r     <= fcg_pkg::RST_TOP_LEFT_RGB;
      tr_rgb_r     <= fcg_pkg::RST_TOP_RIGHT_RGB;
      br_rgb_r     <= fcg_pkg::RST_BOTTOM_RIGHT_RGB;
      bl_rgb_r     <= fcg_pkg::RST_BOTTOM_LEFT_RGB;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fcg_pkg::REG_FRAME_WIDTH:      width_cfg_r  <= cfg_data[fcg_pkg::CFG_SIZE_W-1:0];
        fcg_pkg::REG_FRAME_HEIGHT:     height_cfg_r <= cfg_data[fcg_pkg::CFG_SIZE_W-1:0];
        fcg_pkg::REG_TOP_LEFT_RGB:     tl_rgb_r     <= cfg_data;
        fcg_pkg::REG_TOP_RIGHT_RGB:    tr_rgb_r     <= cfg_data;
        fcg_pkg::REG_BOTTOM_RIGHT_RGB: br_rgb_r     <= cfg_data;
        fcg_pkg::REG_BOTTOM_LEFT_RGB:  bl_rgb_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pending_r <= 1'b1;
      row_pending_r   <= 1'b0;
      out_valid_r     <= 1'b0;
      col_r           <= '0;
      row_r           <= '0;
    end else begin
      if (cmd.frame_load) begin
        start_pending_r <= 1'b0;
        row_pending_r   <= 1'b1;
        col_r           <= '0;
        row_r           <= '0;
      end
      if (cmd.row_load) begin
        row_pending_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (!last_col) begin
          col_r <= col_r + 1'b1;
        end else if (!last_row) begin
          col_r         <= '0;
          row_r         <= row_r + 1'b1;
          row_pending_r <= 1'b1;
        end else begin
          start_pending_r <= 1'b1;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_load) begin
      live_w_r <= fcg_pkg::clamp_size(width_cfg_r, fcg_pkg::MAX_WIDTH_DIM);
      live_h_r <= fcg_pkg::clamp_size(height_cfg_r, fcg_pkg::MAX_HEIGHT_DIM);
      for (int c = 0; c < 3; c++) begin
        left_edge_r[c]  <= fcg_pkg::fix_of(fcg_pkg::chan_byte(tl_rgb_r, 2'(c)));
        right_edge_r[c] <= fcg_pkg::fix_of(fcg_pkg::chan_byte(tr_rgb_r, 2'(c)));
      end
    end
    if (cmd.row_load) begin
      for (int c = 0; c < 3; c++) begin
        row_val_r[c] <= left_edge_r[c];
      end
    end
    if (cmd.div_start) begin
      div_neg_r  <= diff_neg;
      div_zero_r <= (divisor == '0);
    end
    if (cmd.div_write) begin
      if (job_left) begin
        left_step_r[chan] <= step_val;
      end else if (job_right) begin
        right_step_r[chan] <= step_val;
      end else begin
        row_step_r[chan] <= step_val;
      end
    end
    if (cmd.emit) begin
      pix_x_r     <= fcg_pkg::PIX_W'(col_r);
      pix_y_r     <= fcg_pkg::PIX_W'(row_r);
      argb_r      <= {fcg_pkg::ALPHA_OPAQUE,
                      fcg_pkg::chan_out(row_val_r[0]),
                      fcg_pkg::chan_out(row_val_r[1]),
                      fcg_pkg::chan_out(row_val_r[2])};
      frame_end_r <= last_col && last_row;
      if (!last_col) begin
        for (int c = 0; c < 3; c++) begin
          row_val_r[c] <= row_val_r[c] + row_step_r[c];
        end
      end else if (!last_row) begin
        for (int c = 0; c < 3; c++) begin
          left_edge_r[c]  <= left_edge_r[c] + left_step_r[c];
          right_edge_r[c] <= right_edge_r[c] + right_step_r[c];
        end
      end
    end
  end

  always_comb begin
    stat.start_pending = start_pending_r;
    stat.row_pending   = row_pending_r;
    stat.div_done      = div_done;
    stat.out_free      = out_free;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = pix_x_r;
  assign out_pixel_y     = pix_y_r;
  assign out_argb_colour = argb_r;
  assign out_frame_end   = frame_end_r;

endmodule

[design/four_corner_gradient_generator.sv]
// Four-corner gradient test-pattern source: each accepted input word yields the next pixel
// of a raster frame (x, y, ARGB with alpha 255, frame_end on the last pixel), with colour
// blended linearly down the left and right edges and then across each row in signed 9.16
// fixed point. Steps come from one shared bit-serial divider that resolves one quotient
// bit per cycle. A pixel inside a row passes from the idle state through the emit state
// into the result register, waiting in the emit state while out_stall holds the output
// register; no further word is taken until the block is back in idle. The first pixel
// of a row reaches it after the row-step division of each channel; the first pixel of a
// frame, after reset, frame_end or restart_frame, after the edge-step divisions of both
// edges per channel, then the row-step divisions. A new word is taken while a result
// still waits in the output register. Writes via cfg_* take effect at the next frame start.
module four_corner_gradient_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_restart_frame,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fcg_pkg::PIX_W-1:0]      out_pixel_x,
  output logic [fcg_pkg::PIX_W-1:0]      out_pixel_y,
  output logic [fcg_pkg::ARGB_W-1:0]     out_argb_colour,
  output logic                           out_frame_end,
  input  logic                           cfg_wr_en,
  input  logic [fcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcg_pkg::CFG_DATA_W-1:0] cfg_data
);

  fcg_pkg::fcg_cmd_t  cmd;
  fcg_pkg::fcg_stat_t stat;

  fcg_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_restart_frame (in_restart_frame),
    .in_stall         (in_stall),
    .stat             (stat),
    .cmd              (cmd)
  );

  fcg_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_argb_colour (out_argb_colour),
    .out_frame_end   (out_frame_end)
  );

endmodule

[dv/tb.sv]
module tb;
  import fcg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int TARGET_WORDS   = 450;
  localparam int SETTLE_CYCLES  = 300;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 10000;

  typedef struct packed {
    logic [PIX_W-1:0]  col;
    logic [PIX_W-1:0]  row;
    logic [ARGB_W-1:0] argb;
    logic              frame_end;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_restart_frame = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      out_pixel_x;
  logic [PIX_W-1:0]      out_pixel_y;
  logic [ARGB_W-1:0]     out_argb_colour;
  logic                  out_frame_end;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  four_corner_gradient_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart_frame(in_restart_frame),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_argb_colour (out_argb_colour),
    .out_frame_end   (out_frame_end),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bit     pending_words[$];
  pixel_t expected_pixels[$];
  int     words_queued = 0;
  int     words_taken = 0;
  int     error_count = 0;
  logic   in_fire = 1'b0;
  bit     squeeze_req = 1'b0;
  bit     squeeze_done = 1'b0;

  // shadow of the register file
  logic [CFG_SIZE_W-1:0] reg_width  = RST_FRAME_WIDTH;
  logic [CFG_SIZE_W-1:0] reg_height = RST_FRAME_HEIGHT;
  logic [RGB_W-1:0]      rgb_tl     = RST_TOP_LEFT_RGB;
  logic [RGB_W-1:0]      rgb_tr     = RST_TOP_RIGHT_RGB;
  logic [RGB_W-1:0]      rgb_br     = RST_BOTTOM_RIGHT_RGB;
  logic [RGB_W-1:0]      rgb_bl     = RST_BOTTOM_LEFT_RGB;

  // raster state of the gradient
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;
  int unsigned live_w = 32'(RST_FRAME_WIDTH);
  int unsigned live_h = 32'(RST_FRAME_HEIGHT);
  bit          start_due = 1'b1;
  val_t        left_val[3];
  val_t        right_val[3];
  val_t        left_inc[3];
  val_t        right_inc[3];
  val_t        row_val[3];
  val_t        row_inc[3];

  function automatic val_t corner_fix(logic [RGB_W-1:0] rgb, int ch);
    logic [CHAN_W-1:0] b;
    b = CHAN_W'(rgb >> (16 - 8 * ch));
    return val_t'(b) <<< FRACTION_BITS;
  endfunction

  function automatic val_t ramp_step(val_t diff, int unsigned n);
    if (n <= 1) begin
      return '0;
    end
    return val_t'(longint'(diff) / longint'(n - 1));
  endfunction

  function automatic int unsigned clamp_dim(logic [CFG_SIZE_W-1:0] v, int unsigned maxv);
    if (v == 0) begin
      return 1;
    end else if (32'(v) > maxv) begin
      return maxv;
    end
    return 32'(v);
  endfunction

  function automatic logic [CHAN_W-1:0] shade(val_t v);
    if (v < 0) begin
      return '0;
    end else if ((v >>> FRACTION_BITS) > 255) begin
      return 8'hFF;
    end
    return v[FRACTION_BITS+CHAN_W-1:FRACTION_BITS];
  endfunction

  function automatic void load_row();
    for (int c = 0; c < 3; c++) begin
      row_val[c] = left_val[c];
      row_inc[c] = ramp_step(right_val[c] - left_val[c], live_w);
    end
  endfunction

  function automatic void begin_frame();
    live_w = clamp_dim(reg_width, MAX_WIDTH);
    live_h = clamp_dim(reg_height, MAX_HEIGHT);
    for (int c = 0; c < 3; c++) begin
      left_val[c]  = corner_fix(rgb_tl, c);
      right_val[c] = corner_fix(rgb_tr, c);
      left_inc[c]  = ramp_step(corner_fix(rgb_bl, c) - left_val[c], live_h);
      right_inc[c] = ramp_step(corner_fix(rgb_br, c) - right_val[c], live_h);
    end
    col_cnt = 0;
    row_cnt = 0;
    load_row();
    start_due = 1'b0;
  endfunction

  function automatic pixel_t next_pixel(bit restart);
    pixel_t p;
    bit     last_col;
    bit     last_row;
    if (restart || start_due) begin
      begin_frame();
    end
    last_col = (col_cnt + 1 >= live_w);
    last_row = (row_cnt + 1 >= live_h);
    p.col = PIX_W'(col_cnt);
    p.row = PIX_W'(row_cnt);
    p.argb = {ALPHA_OPAQUE, shade(row_val[0]), shade(row_val[1]), shade(row_val[2])};
    p.frame_end = last_col && last_row;
    if (!last_col) begin
      col_cnt++;
      for (int c = 0; c < 3; c++) begin
        row_val[c] = row_val[c] + row_inc[c];
      end
    end else if (!last_row) begin
      col_cnt = 0;
      row_cnt++;
      for (int c = 0; c < 3; c++) begin
        left_val[c]  = left_val[c] + left_inc[c];
        right_val[c] = right_val[c] + right_inc[c];
      end
      load_row();
    end else begin
      start_due = 1'b1;
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : monitor
    pixel_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FRAME_WIDTH:      reg_width  = cfg_data[CFG_SIZE_W-1:0];
          REG_FRAME_HEIGHT:     reg_height = cfg_data[CFG_SIZE_W-1:0];
          REG_TOP_LEFT_RGB:     rgb_tl     = cfg_data[RGB_W-1:0];
          REG_TOP_RIGHT_RGB:    rgb_tr     = cfg_data[RGB_W-1:0];
          REG_BOTTOM_RIGHT_RGB: rgb_br     = cfg_data[RGB_W-1:0];
          REG_BOTTOM_LEFT_RGB:  rgb_bl     = cfg_data[RGB_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(next_pixel(in_restart_frame));
        words_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected word", out_argb_colour, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_x !== want.col) begin
            report_mismatch("pixel_x", 32'(out_pixel_x), 32'(want.col));
          end
          if (out_pixel_y !== want.row) begin
            report_mismatch("pixel_y", 32'(out_pixel_y), 32'(want.row));
          end
          if (out_argb_colour !== want.argb) begin
            report_mismatch("argb_colour", out_argb_colour, want.argb);
          end
          if (out_frame_end !== want.frame_end) begin
            report_mismatch("frame_end", 32'(out_frame_end), 32'(want.frame_end));
          end
        end
      end
    end
  end

  int sender_gap = 0;
  bit sender_calm = 1'b0;

  function automatic int gap_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_restart_frame <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (sender_gap > 0) begin
        sender_gap--;
        in_valid <= 1'b0;
        in_restart_frame <= 1'($urandom);
      end else if (pending_words.size() > 0) begin
        in_valid <= 1'b1;
        in_restart_frame <= pending_words.pop_front();
        sender_gap = gap_len(sender_calm);
        if ($urandom_range(0, 31) == 0) begin
          sender_calm = !sender_calm;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  int stall_run = 0;
  bit stall_level = 1'b0;

  always @(negedge clk) begin
    int r;
    if (rst_n) begin
      if (stall_run == 0) begin
        r = $urandom_range(0, 99);
        if (squeeze_req && !squeeze_done) begin
          stall_level = 1'b1;
          stall_run = SQUEEZE_CYCLES;
          squeeze_done = 1'b1;
        end else if (r < 50) begin
          stall_level = 1'b0;
          stall_run = $urandom_range(1, 30);
        end else if (r < 85) begin
          stall_level = 1'b1;
          stall_run = $urandom_range(1, 3);
        end else begin
          stall_level = 1'b1;
          stall_run = $urandom_range(10, 50);
        end
      end
      out_stall <= stall_level;
      stall_run--;
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic push_word(bit restart);
    pending_words.push_back(restart);
    words_queued++;
  endtask

  task automatic drain();
    while (words_taken != words_queued || expected_pixels.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic program_frame(logic [CFG_SIZE_W-1:0] w, logic [CFG_SIZE_W-1:0] h,
                               logic [RGB_W-1:0] tl, logic [RGB_W-1:0] tr,
                               logic [RGB_W-1:0] br, logic [RGB_W-1:0] bl);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_TOP_LEFT_RGB, tl);
    write_reg(REG_TOP_RIGHT_RGB, tr);
    write_reg(REG_BOTTOM_RIGHT_RGB, br);
    write_reg(REG_BOTTOM_LEFT_RGB, bl);
  endtask

  function automatic logic [CFG_SIZE_W-1:0] rand_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return CFG_SIZE_W'($urandom_range(1, 6));
    end else if (r < 88) begin
      return CFG_SIZE_W'($urandom_range(7, 40));
    end else if (r < 92) begin
      return CFG_SIZE_W'(MAX_WIDTH);
    end else if (r < 95) begin
      return '0;
    end
    return CFG_SIZE_W'($urandom_range(1025, 2047));
  endfunction

  function automatic logic [RGB_W-1:0] rand_rgb();
    logic [RGB_W-1:0] rgb;
    int               r;
    for (int c = 0; c < 3; c++) begin
      r = $urandom_range(0, 9);
      rgb = rgb << CHAN_W;
      if (r < 2) begin
        rgb[CHAN_W-1:0] = 8'h00;
      end else if (r < 4) begin
        rgb[CHAN_W-1:0] = 8'hFF;
      end else begin
        rgb[CHAN_W-1:0] = CHAN_W'($urandom_range(0, 255));
      end
    end
    return rgb;
  endfunction

  initial begin
    int phase_no;
    int n;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // first frame runs on reset settings
    push_word(1'b0);
    push_word(1'b0);
    push_word(1'b0);
    push_word(1'b1);
    push_word(1'b0);
    settle();

    program_frame(11'd1, 11'd1, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    push_word(1'b1);
    push_word(1'b0);
    push_word(1'b0);
    settle();

    program_frame(11'd0, 11'd0, 24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF);
    push_word(1'b0);
    push_word(1'b0);
    settle();

    program_frame(11'd2, 11'd2, 24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00);
    repeat (5) push_word(1'b0);
    settle();

    program_frame(11'd2047, 11'd2047, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
    push_word(1'b1);
    push_word(1'b0);
    push_word(1'b0);
    push_word(1'b1);
    push_word(1'b0);
    settle();

    program_frame(11'd1024, 11'd1, 24'h808080, 24'h7F7F7F, 24'h123456, 24'hEDCBA9);
    push_word(1'b1);
    push_word(1'b0);
    settle();

    program_frame(11'd1, 11'd5, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h00FFFF);
    push_word(1'b1);
    repeat (5) push_word(1'b0);

    phase_no = 0;
    while (words_queued < TARGET_WORDS) begin
      settle();
      program_frame(rand_dim(), rand_dim(), rand_rgb(), rand_rgb(), rand_rgb(), rand_rgb());
      n = $urandom_range(8, 40);
      if (phase_no == 2) begin
        squeeze_req = 1'b1;
        n = 60;
      end
      for (int i = 0; i < n; i++) begin
        if (i == 0) begin
          push_word($urandom_range(0, 9) < 7);
        end else begin
          push_word($urandom_range(0, 99) < 5);
        end
      end
      phase_no++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
